FILE: sv/fbrd_pkg.sv
// shared types and constants for the byte-run line decoder
package fbrd_pkg;

  // configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_TOTAL = 1'b1;

  // configuration reset values
  localparam logic [15:0] LINE_WIDTH_RST = 16'd320;
  localparam logic [15:0] LINE_TOTAL_RST = 16'd200;

  // default depth of the command queue between parser and expander
  localparam int QUEUE_DEPTH_DEF = 4;

  // parser phases
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_COUNT   = 2'd1,
    PH_RUNVAL  = 2'd2,
    PH_LITERAL = 2'd3
  } phase_t;

  // one expansion command: repeat value len times, with line/frame flags
  typedef struct packed {
    logic [7:0] value;
    logic [6:0] len;
    logic       eol;
    logic       eof;
    logic       ovr;
  } fbrd_cmd_t;

endpackage

FILE: sv/fbrd_front.sv
// stream parser: consumes code bytes, tracks line state, issues pixel commands
module fbrd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_code_byte,
  input  logic [15:0]         line_width,
  input  logic [15:0]         line_total,
  input  logic                q_full,
  output logic                cmd_push,
  output fbrd_pkg::fbrd_cmd_t cmd
);
  import fbrd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pix_left_r, pix_left_nxt;
  logic [7:0]  pkt_left_r, pkt_left_nxt;
  logic [6:0]  run_len_r, run_len_nxt;
  logic [15:0] lines_done_r, lines_done_nxt;
  logic        pkt_ovr_r, pkt_ovr_nxt;

  logic        acc;
  logic [15:0] eff_width;
  logic        run_big;
  logic [15:0] run_n;
  logic [15:0] run_left_after;
  logic        run_eol;
  logic [15:0] lines_inc;
  logic        frame_done;
  logic [7:0]  pkt_after;
  logic [7:0]  lit_len;
  logic        lit_has_pix;
  logic        lit_eol;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // shared arithmetic
  assign eff_width      = (line_width == 16'd0) ? 16'd1 : line_width;
  assign run_big        = {9'd0, run_len_r} > pix_left_r;
  assign run_n          = run_big ? pix_left_r : {9'd0, run_len_r};
  assign run_left_after = pix_left_r - run_n;
  assign run_eol        = (run_left_after == 16'd0);
  assign lines_inc      = lines_done_r + 16'd1;
  assign frame_done     = (lines_inc >= line_total);
  assign pkt_after      = (pkt_left_r != 8'd0) ? pkt_left_r - 8'd1 : pkt_left_r;
  assign lit_has_pix    = (pix_left_r != 16'd0);
  assign lit_eol        = (pix_left_r == 16'd1);
  assign lit_len        = 8'd0 - in_code_byte;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        if (in_code_byte == 8'd0) begin
          phase_nxt = PH_COUNT;
        end else if (!in_code_byte[7]) begin
          phase_nxt = PH_RUNVAL;
        end else begin
          phase_nxt = PH_LITERAL;
        end
      end
      PH_RUNVAL: begin
        phase_nxt = run_eol ? PH_HEADER : PH_COUNT;
      end
      PH_LITERAL: begin
        if (pkt_after == 8'd0) begin
          phase_nxt = (lit_has_pix && !lit_eol) ? PH_COUNT : PH_HEADER;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  // counters and command output
  always_comb begin
    pix_left_nxt   = pix_left_r;
    pkt_left_nxt   = pkt_left_r;
    run_len_nxt    = run_len_r;
    lines_done_nxt = lines_done_r;
    pkt_ovr_nxt    = pkt_ovr_r;
    cmd_push       = 1'b0;
    cmd.value      = in_code_byte;
    cmd.len        = 7'd1;
    cmd.eol        = 1'b0;
    cmd.eof        = 1'b0;
    cmd.ovr        = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        pix_left_nxt = eff_width;
      end
      PH_COUNT: begin
        if (in_code_byte != 8'd0) begin
          if (!in_code_byte[7]) begin
            run_len_nxt = in_code_byte[6:0];
          end else begin
            pkt_left_nxt = lit_len;
            pkt_ovr_nxt  = {8'd0, lit_len} > pix_left_r;
          end
        end
      end
      PH_RUNVAL: begin
        pix_left_nxt = run_left_after;
        run_len_nxt  = 7'd0;
        cmd_push     = acc && (run_n != 16'd0);
        cmd.len      = run_n[6:0];
        cmd.eol      = run_eol;
        cmd.eof      = run_eol && frame_done;
        cmd.ovr      = run_big;
        if (run_eol) begin
          lines_done_nxt = frame_done ? 16'd0 : lines_inc;
        end
      end
      PH_LITERAL: begin
        if (lit_has_pix) begin
          pix_left_nxt = pix_left_r - 16'd1;
          cmd_push     = acc;
          cmd.eol      = lit_eol;
          cmd.eof      = lit_eol && frame_done;
          cmd.ovr      = pkt_ovr_r;
          if (lit_eol) begin
            lines_done_nxt = frame_done ? 16'd0 : lines_inc;
          end
        end
        pkt_left_nxt = pkt_after;
        if (pkt_after == 8'd0) begin
          pkt_ovr_nxt = 1'b0;
        end
      end
      default: begin
        pix_left_nxt = pix_left_r;
      end
    endcase
  end

  // state registers, advanced on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      pix_left_r   <= LINE_WIDTH_RST;
      pkt_left_r   <= 8'd0;
      run_len_r    <= 7'd0;
      lines_done_r <= 16'd0;
      pkt_ovr_r    <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      pix_left_r   <= pix_left_nxt;
      pkt_left_r   <= pkt_left_nxt;
      run_len_r    <= run_len_nxt;
      lines_done_r <= lines_done_nxt;
      pkt_ovr_r    <= pkt_ovr_nxt;
    end
  end

endmodule

FILE: sv/fbrd_queue.sv
// small command fifo between parser and expander
module fbrd_queue #(
  parameter int DEPTH = fbrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fbrd_pkg::fbrd_cmd_t push_cmd,
  input  logic                pop,
  output fbrd_pkg::fbrd_cmd_t head_cmd,
  output logic                empty,
  output logic                full
);
  import fbrd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fbrd_cmd_t         slots_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign empty    = (count_r == CW'(0));
  assign full     = (count_r == CW'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots_r[rd_ptr_r];

  // pointer and fill count update, wrapping at depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/fbrd_back.sv
// run expander: turns commands into results of up to two pixels
module fbrd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  fbrd_pkg::fbrd_cmd_t head_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_pixel_first,
  output logic [7:0]          out_pixel_second,
  output logic [1:0]          out_pixel_count,
  output logic                out_last_of_run,
  output logic                out_end_of_line,
  output logic                out_end_of_frame,
  output logic                out_overrun
);
  import fbrd_pkg::*;

  logic       active_r, active_nxt;
  fbrd_cmd_t  cur_r, cur_nxt;
  logic [6:0] left_r, left_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] first_r, second_r;
  logic [1:0] count_r;
  logic       last_r, eol_r, eof_r, ovr_r;

  logic       can_load;
  logic       emit;
  logic       two;
  logic       last;

  assign can_load = !out_valid_r || out_ready;
  assign emit     = active_r && can_load;
  assign two      = (left_r >= 7'd2);
  assign last     = (left_r <= 7'd2);
  assign q_pop    = !q_empty && (!active_r || (emit && last));

  // command tracking
  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    left_nxt   = left_r;
    if (emit) begin
      left_nxt = two ? left_r - 7'd2 : left_r - 7'd1;
      if (last) begin
        active_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      active_nxt = 1'b1;
      cur_nxt    = head_cmd;
      left_nxt   = head_cmd.len;
    end
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      left_r      <= 7'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command payload and output register
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      first_r  <= cur_r.value;
      second_r <= two ? cur_r.value : 8'd0;
      count_r  <= two ? 2'd2 : 2'd1;
      last_r   <= last;
      eol_r    <= last && cur_r.eol;
      eof_r    <= last && cur_r.eof;
      ovr_r    <= cur_r.ovr;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_first  = first_r;
  assign out_pixel_second = second_r;
  assign out_pixel_count  = count_r;
  assign out_last_of_run  = last_r;
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;
  assign out_overrun      = ovr_r;

endmodule

FILE: sv/fli_byte_run_decoder.sv
// top level of the byte-run line decoder with its configuration registers
//
// The decoder takes one compressed code byte per cycle whenever its command
// queue (QUEUE_DEPTH entries) has room. Header, count and skipped bytes give
// no result, nor do literal bytes past the end of the line. A run byte of
// length n, clamped to the pixels left in the line, becomes one queued
// command that the expander plays out as ceil(n/2) results, one per cycle
// while the receiver is ready, two pixels each except possibly the last; a
// literal byte inside the line gives one single-pixel result. Sustained
// input rate is therefore one byte per cycle until the expander falls
// behind on long runs, after which the queue fills and input waits for room.
// Registers: line_width at address 0, line_total at address 4, both 16 bits;
// a line_width change takes effect at the next line header.
module fli_byte_run_decoder #(
  parameter int QUEUE_DEPTH = fbrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_code_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_first,
  output logic [7:0]  out_pixel_second,
  output logic [1:0]  out_pixel_count,
  output logic        out_last_of_run,
  output logic        out_end_of_line,
  output logic        out_end_of_frame,
  output logic        out_overrun,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fbrd_pkg::*;

  logic [15:0] line_width_r;
  logic [15:0] line_total_r;
  logic        cfg_wr;

  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  fbrd_cmd_t   push_cmd;
  fbrd_cmd_t   head_cmd;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
      line_total_r <= LINE_TOTAL_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LINE_WIDTH: line_width_r <= pwdata[15:0];
        REG_LINE_TOTAL: line_total_r <= pwdata[15:0];
        default: begin
          line_width_r <= line_width_r;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_LINE_WIDTH: prdata = {16'd0, line_width_r};
      REG_LINE_TOTAL: prdata = {16'd0, line_total_r};
      default:        prdata = 32'd0;
    endcase
  end

  // parser
  fbrd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .line_width   (line_width_r),
    .line_total   (line_total_r),
    .q_full       (q_full),
    .cmd_push     (q_push),
    .cmd          (push_cmd)
  );

  // command queue
  fbrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  // expander
  fbrd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head_cmd         (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixel_count  (out_pixel_count),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_overrun      (out_overrun)
  );

  // checks
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pixel_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_count == 2'd1 || out_pixel_count == 2'd2))
    else $error("result pixel count out of range");

  a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_count == 2'd1) |-> (out_pixel_second == 8'd0))
    else $error("second pixel not cleared on single-pixel result");

  a_eof_implies_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> (out_end_of_line && out_last_of_run))
    else $error("frame end without line end on last result");

endmodule

FILE: tb/sv/fli_byte_run_decoder_test.sv
// self-checking testbench for the byte-run line decoder: directed packets, random streams
module fli_byte_run_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fbrd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 24;

  // one expected result: up to two pixels with their flags
  typedef struct packed {
    logic [7:0] pix_first;
    logic [7:0] pix_second;
    logic [1:0] pix_count;
    logic       last_run;
    logic       eol;
    logic       eof;
    logic       ovr;
  } pixel_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_code_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_first;
  logic [7:0]  out_pixel_second;
  logic [1:0]  out_pixel_count;
  logic        out_last_of_run;
  logic        out_end_of_line;
  logic        out_end_of_frame;
  logic        out_overrun;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // decoder state as the testbench tracks it
  logic [15:0] width_reg = LINE_WIDTH_RST;
  logic [15:0] total_reg = LINE_TOTAL_RST;
  phase_t      phase = PH_HEADER;
  int          pix_left = int'(LINE_WIDTH_RST);
  int          lit_left = 0;
  logic [6:0]  run_len = 7'd0;
  logic [15:0] lines_done = 16'd0;
  logic        lit_ovr = 1'b0;

  pixel_pair_t pixel_pairs_due[$];

  int codes_taken = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  int rx_hold     = 0;
  int rx_wait     = 0;
  bit tx_burst    = 1'b0;
  bit rx_burst    = 1'b0;

  always #10 clk = ~clk;

  fli_byte_run_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_byte     (in_code_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_first  (out_pixel_first),
    .out_pixel_second (out_pixel_second),
    .out_pixel_count  (out_pixel_count),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_line  (out_end_of_line),
    .out_end_of_frame (out_end_of_frame),
    .out_overrun      (out_overrun),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // count a finished line, report whether it closes the frame
  function automatic logic close_line();
    lines_done = lines_done + 16'd1;
    if (lines_done >= total_reg) begin
      lines_done = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the decoder state by one code byte and queue the pixels it yields
  task automatic decode_code(input logic [7:0] b);
    int          n;
    int          c;
    logic        eol;
    logic        eof;
    logic        ovr;
    pixel_pair_t p;
    eol = 1'b0;
    eof = 1'b0;
    ovr = 1'b0;
    case (phase)
      PH_HEADER: begin
        pix_left = (width_reg == 16'd0) ? 1 : int'(width_reg);
        phase = PH_COUNT;
      end
      PH_COUNT: begin
        // zero count leaves the phase alone
        if (b != 8'h00) begin
          if (!b[7]) begin
            run_len = b[6:0];
            phase = PH_RUNVAL;
          end else begin
            lit_left = 256 - int'(b);
            lit_ovr = (lit_left > pix_left);
            phase = PH_LITERAL;
          end
        end
      end
      PH_RUNVAL: begin
        n = int'(run_len);
        if (n > pix_left) begin
          n = pix_left;
          ovr = 1'b1;
        end
        pix_left -= n;
        if (pix_left == 0) begin
          eol = 1'b1;
          eof = close_line();
        end
        // split the run into pairs, odd pixel last
        while (n > 0) begin
          c = (n >= 2) ? 2 : 1;
          p.pix_first  = b;
          p.pix_second = (c == 2) ? b : 8'h00;
          p.pix_count  = 2'(c);
          p.last_run   = (n == c);
          p.eol        = (n == c) && eol;
          p.eof        = (n == c) && eof;
          p.ovr        = ovr;
          pixel_pairs_due.push_back(p);
          n -= c;
        end
        run_len = 7'd0;
        if (eol) phase = PH_HEADER;
        else phase = PH_COUNT;
      end
      default: begin
        // literal bytes past the end of line are swallowed
        if (pix_left > 0) begin
          pix_left--;
          if (pix_left == 0) begin
            eol = 1'b1;
            eof = close_line();
          end
          p = '{b, 8'h00, 2'd1, 1'b1, eol, eof, lit_ovr};
          pixel_pairs_due.push_back(p);
        end
        if (lit_left > 0) lit_left--;
        if (lit_left == 0) begin
          if (pix_left == 0) phase = PH_HEADER;
          else phase = PH_COUNT;
          lit_ovr = 1'b0;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // input and result handshakes, taken in a fixed order each edge
  always @(posedge clk) begin : monitor
    pixel_pair_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_code(in_code_byte);
        codes_taken++;
      end
      if (out_valid && out_ready) begin
        if (pixel_pairs_due.size() == 0) begin
          $error("unexpected result: pixel_first %0h, pixel_count %0d",
                 out_pixel_first, out_pixel_count);
          fail_count++;
        end else begin
          want = pixel_pairs_due.pop_front();
          check_field("pixel_first", want.pix_first, out_pixel_first);
          check_field("pixel_second", want.pix_second, out_pixel_second);
          check_field("pixel_count", 8'(want.pix_count), 8'(out_pixel_count));
          check_field("last_of_run", 8'(want.last_run), 8'(out_last_of_run));
          check_field("end_of_line", 8'(want.eol), 8'(out_end_of_line));
          check_field("end_of_frame", 8'(want.eof), 8'(out_end_of_frame));
          check_field("overrun", 8'(want.ovr), 8'(out_overrun));
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: long hold first, then the per-item wait
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // offer one code byte after a random gap and wait until it is taken
  task automatic send_code(input logic [7:0] b);
    int gap;
    int target;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    target = codes_taken + 1;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_code_byte <= b;
    wait (codes_taken == target);
  endtask

  // stop offering, let every expected item arrive, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pixel_pairs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_reg(input logic reg_idx, input logic [15:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_idx == REG_LINE_WIDTH) width_reg = value;
    else total_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value) begin
      $error("prdata: expected %0h, got %0h", value, prdata[15:0]);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] width, input logic [15:0] lines);
    settle();
    write_reg(REG_LINE_WIDTH, width);
    write_reg(REG_LINE_TOTAL, lines);
  endtask

  // next byte of a mostly well-formed stream, steered by the current phase
  function automatic logic [7:0] pick_code();
    int roll;
    int room;
    roll = $urandom_range(0, 99);
    room = (pix_left > 40) ? 40 : pix_left;
    if (phase != PH_COUNT || roll < 8) return 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 6) return 8'h00;
    if (roll < 7) return 8'h80;
    // counts that may run past the end of line
    if (roll < 17) return 8'($urandom_range(1, 127));
    if (roll < 24) return 8'(256 - $urandom_range(1, 127));
    // counts that fit the line
    if (roll < 62) return 8'($urandom_range(1, room));
    return 8'(256 - $urandom_range(1, (room > 8) ? 8 : room));
  endfunction

  // reset geometry: three long runs, the last clamped at 320
  task automatic test_reset_values();
    logic [7:0] codes[$];
    codes = '{8'h3C, 8'h7F, 8'h11, 8'h7F, 8'h22, 8'h7F, 8'h33};
    foreach (codes[i]) send_code(codes[i]);
  endtask

  // short lines: zero count, runs, literals, clamped run, literal overflow
  task automatic test_directed_packets();
    logic [7:0] codes[$];
    set_geometry(16'd5, 16'd2);
    codes = '{8'h11, 8'h00, 8'h03, 8'hFF, 8'hFE, 8'h00, 8'h80,
              8'hEE, 8'h7F, 8'h55,
              8'h00, 8'h01, 8'h01, 8'hFB, 8'h7F, 8'hFE, 8'h01, 8'h02, 8'hAA,
              8'hFF, 8'h05, 8'h5A};
    foreach (codes[i]) send_code(codes[i]);
  endtask

  // zero width and zero line total, then a 128-byte literal on a 1-pixel line
  task automatic test_degenerate_sizes();
    logic [7:0] codes[$];
    set_geometry(16'd0, 16'd0);
    codes = '{8'h01, 8'hFE, 8'hAB, 8'hCD, 8'h02, 8'h02, 8'h77, 8'h03, 8'h80};
    foreach (codes[i]) send_code(codes[i]);
    repeat (128) send_code(8'($urandom_range(0, 255)));
  endtask

  // long receiver hold while long runs keep coming
  task automatic test_backpressure();
    set_geometry(16'd2000, 16'd3);
    tx_burst = 1'b1;
    rx_hold = 300;
    send_code(8'h5A);
    repeat (10) begin
      send_code(8'($urandom_range(60, 127)));
      send_code(8'($urandom_range(0, 255)));
    end
    tx_burst = 1'b0;
  endtask

  task automatic random_phase(input logic [15:0] width, input logic [15:0] lines,
                              input int n_codes);
    set_geometry(width, lines);
    for (int i = 0; i < n_codes; i++) begin
      // switch between idling and back-to-back stretches
      if (i % 16 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_code(pick_code());
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_random_stream();
    random_phase(16'd7, 16'd3, 12);
    random_phase(16'd33, 16'd5, 10);
    // total drops below the lines already done
    random_phase(16'd1, 16'd1, 5);
    random_phase(16'd2, 16'd0, 5);
    random_phase(16'hFFFF, 16'hFFFF, 5);
    random_phase(16'd12, 16'd2, 8);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_packets();
    test_degenerate_sizes();
    test_backpressure();
    test_random_stream();
    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/fbrd_pkg.sv
sv/fbrd_front.sv
sv/fbrd_queue.sv
sv/fbrd_back.sv
sv/fli_byte_run_decoder.sv
tb/sv/fli_byte_run_decoder_test.sv
